// File: rtl/tbp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the token bucket policer.
// No dependencies; used by token_bucket_policer.
package tbp_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_BURST_LIMIT   = 2'd0;
    localparam logic [1:0] REG_LOW_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_RATE          = 2'd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_FORWARD    = 2'd0;
    localparam logic [1:0] VERDICT_EARLY_DROP = 2'd1;
    localparam logic [1:0] VERDICT_QUEUE      = 2'd2;

    localparam logic [31:0] BURST_RESET = 32'd16384;
    localparam logic [31:0] MS_DIVISOR  = 32'd8000;

    // 2^32 split as WORD_QUOT * 8000 + WORD_REM, used to fold the high product word
    localparam logic [31:0] WORD_QUOT = 32'd536870;
    localparam logic [32:0] WORD_REM  = 33'd7296;
    // ceil(2^34 / 125): exact quotient by 125 for dividends below 2^27
    localparam logic [31:0] RECIP_125 = 32'd137438954;

    // Modulo step count, loaded as count minus one
    localparam logic [5:0] MOD_STEPS_M1  = 6'd30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPLIT,
        ST_RECIP,
        ST_CLAMP,
        ST_FIT,
        ST_MOD,
        ST_DECIDE,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/token_bucket_policer.sv
`timescale 1ns / 1ps
// Token bucket policer with random early drop, single module.
// Depends on tbp_pkg for state type, register indexes and verdict codes.

// One packet at a time: in_stall is high from the transfer of a packet until
// its verdict is loaded into the output register. One shared multiplier forms
// the product of elapsed time and rate, and then, after the high product word
// is folded down, divides it by 8000 with a reciprocal multiply; the refill gain
// is registered in RECIP. The early drop modulo (random word by the low
// threshold) runs on a restoring divider that retires one quotient bit per cycle
// in MOD; DECIDE sets the verdict. With a nonzero rate a packet goes through
// MUL, SPLIT, RECIP, CLAMP, FIT and FINISH, plus MOD and DECIDE when the refilled
// bucket sits below the low threshold and the packet fits; bypass (zero rate)
// goes straight to FINISH, which waits for a held previous result to transfer.
module token_bucket_policer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic [15:0] packet_bytes,
    input  logic [30:0] random_word,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic [31:0] bucket_level,
    output logic [31:0] empty_count,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    tbp_pkg::state_t state_reg, state_next;

    logic [31:0] burst_reg, thr_reg, rate_reg;
    logic [31:0] fill_reg, fill_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] now_reg;
    logic [15:0] size_reg;
    logic [30:0] rnd_reg;
    logic [1:0]  verdict_reg, verdict_next;

    // Shared divider: dividend shifts left, quotient bits enter at the bottom
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  step_reg, step_next;

    logic        out_valid_reg;
    logic [1:0]  out_verdict_reg;
    logic [31:0] out_level_reg, out_count_reg;

    logic        in_xfer, out_load, out_free;
    logic [32:0] div_shift;
    logic [33:0] div_diff;
    logic        div_qbit;
    logic [31:0] div_rem;
    logic [31:0] elapsed;
    logic [64:0] refill_sum;

    // Shared multiplier and the fold of the product by 8000
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [12:0] prod_hi;
    logic        gain_sat;
    logic [32:0] fold_sum;
    logic [31:0] fold_quot;
    logic [32:0] gain_sum;

    assign in_stall  = (state_reg != tbp_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == tbp_pkg::ST_FINISH) && out_free;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign verdict      = out_verdict_reg;
    assign bucket_level = out_level_reg;
    assign empty_count  = out_count_reg;

    // One restoring divide step
    assign div_shift = {rem_reg, dvd_reg[63]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, dsr_reg};
    assign div_qbit  = !div_diff[33];
    assign div_rem   = div_qbit ? div_diff[31:0] : div_shift[31:0];

    assign elapsed    = now_reg - last_reg;
    assign refill_sum = {33'd0, fill_reg} + {1'b0, dvd_reg};

    assign mul_a = (state_reg == tbp_pkg::ST_MUL) ? elapsed : {5'd0, dvd_reg[32:6]};
    assign mul_b = (state_reg == tbp_pkg::ST_MUL) ? rate_reg : tbp_pkg::RECIP_125;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // A high word of 8000 or more means a gain of at least 2^32: the bucket clamps
    assign gain_sat  = (dvd_reg[63:32] >= tbp_pkg::MS_DIVISOR);
    assign prod_hi   = dvd_reg[44:32];
    assign fold_sum  = {20'd0, prod_hi} * tbp_pkg::WORD_REM + {1'b0, dvd_reg[31:0]};
    assign fold_quot = {19'd0, prod_hi} * tbp_pkg::WORD_QUOT;
    assign gain_sum  = {1'b0, rem_reg} + {12'd0, mul_p[54:34]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbp_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (rate_reg == 32'd0) ? tbp_pkg::ST_FINISH : tbp_pkg::ST_MUL;
                end
            end
            tbp_pkg::ST_MUL:
            begin
                state_next = tbp_pkg::ST_SPLIT;
            end
            tbp_pkg::ST_SPLIT:
            begin
                state_next = tbp_pkg::ST_RECIP;
            end
            tbp_pkg::ST_RECIP:
            begin
                state_next = tbp_pkg::ST_CLAMP;
            end
            tbp_pkg::ST_CLAMP:
            begin
                state_next = tbp_pkg::ST_FIT;
            end
            tbp_pkg::ST_FIT:
            begin
                if ({16'd0, size_reg} <= fill_reg && fill_reg < thr_reg)
                begin
                    state_next = tbp_pkg::ST_MOD;
                end
                else
                begin
                    state_next = tbp_pkg::ST_FINISH;
                end
            end
            tbp_pkg::ST_MOD:
            begin
                if (step_reg == 6'd0)
                begin
                    state_next = tbp_pkg::ST_DECIDE;
                end
            end
            tbp_pkg::ST_DECIDE:
            begin
                state_next = tbp_pkg::ST_FINISH;
            end
            tbp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = tbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tbp_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath updates per state
    always_comb
    begin
        fill_next    = fill_reg;
        last_next    = last_reg;
        cnt_next     = cnt_reg;
        verdict_next = verdict_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dsr_next     = dsr_reg;
        step_next    = step_reg;
        unique case (state_reg)
            tbp_pkg::ST_IDLE:
            begin
                verdict_next = tbp_pkg::VERDICT_FORWARD;
            end
            tbp_pkg::ST_MUL:
            begin
                dvd_next  = mul_p;
                last_next = now_reg;
            end
            tbp_pkg::ST_SPLIT:
            begin
                // hold the saturation flag on top, the folded low part below,
                // and the quotient of the high word in rem_reg
                dvd_next = {gain_sat, 30'd0, fold_sum};
                rem_next = fold_quot;
            end
            tbp_pkg::ST_RECIP:
            begin
                if (dvd_reg[63])
                begin
                    dvd_next = 64'h0000_0001_0000_0000;
                end
                else
                begin
                    dvd_next = {31'd0, gain_sum};
                end
            end
            tbp_pkg::ST_MOD:
            begin
                dvd_next  = {dvd_reg[62:0], div_qbit};
                rem_next  = div_rem;
                step_next = step_reg - 6'd1;
            end
            tbp_pkg::ST_CLAMP:
            begin
                // clamp the refilled level to the burst limit
                if (refill_sum > {33'd0, burst_reg})
                begin
                    fill_next = burst_reg;
                end
                else
                begin
                    fill_next = refill_sum[31:0];
                end
            end
            tbp_pkg::ST_FIT:
            begin
                if ({16'd0, size_reg} > fill_reg)
                begin
                    cnt_next     = cnt_reg + 32'd1;
                    verdict_next = tbp_pkg::VERDICT_QUEUE;
                end
                else if (fill_reg < thr_reg)
                begin
                    dvd_next  = {rnd_reg, 33'd0};
                    rem_next  = 32'd0;
                    dsr_next  = thr_reg;
                    step_next = tbp_pkg::MOD_STEPS_M1;
                end
                else
                begin
                    fill_next = fill_reg - {16'd0, size_reg};
                end
            end
            tbp_pkg::ST_DECIDE:
            begin
                if (fill_reg <= rem_reg)
                begin
                    cnt_next     = cnt_reg + 32'd1;
                    verdict_next = tbp_pkg::VERDICT_EARLY_DROP;
                end
                else
                begin
                    fill_next = fill_reg - {16'd0, size_reg};
                end
            end
            tbp_pkg::ST_FINISH:
            begin
                verdict_next = verdict_reg;
            end
            default:
            begin
                verdict_next = verdict_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbp_pkg::ST_IDLE;
            burst_reg     <= tbp_pkg::BURST_RESET;
            thr_reg       <= 32'd0;
            rate_reg      <= 32'd0;
            fill_reg      <= tbp_pkg::BURST_RESET;
            last_reg      <= 32'd0;
            cnt_reg       <= 32'd0;
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tbp_pkg::REG_BURST_LIMIT:   burst_reg <= cfg_data;
                    tbp_pkg::REG_LOW_THRESHOLD: thr_reg   <= cfg_data;
                    tbp_pkg::REG_RATE:          rate_reg  <= cfg_data;
                    default:                    rate_reg  <= rate_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        if (in_xfer)
        begin
            now_reg  <= now_ms;
            size_reg <= packet_bytes;
            rnd_reg  <= random_word;
        end
        if (out_load)
        begin
            out_verdict_reg <= verdict_reg;
            out_level_reg   <= fill_reg;
            out_count_reg   <= cnt_reg;
        end
    end

endmodule
